FILE: hw/rtl/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg: shared types and constants for the polyline ribbon expander
// Item payload structs, configuration register indexes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prx_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned NORM_TOP    = 30;
  localparam logic [10:0] MAX_POINTS  = 11'd1024;  // MAX_VERTICES / 2
  localparam logic [16:0] TEX_ONE     = 17'd65536;

  typedef enum logic [2:0] {
    CFG_RIBBON_WIDTH = 3'd0,
    CFG_FACING_MODE  = 3'd1,
    CFG_CAM_X        = 3'd2,
    CFG_CAM_Y        = 3'd3,
    CFG_CAM_Z        = 3'd4,
    CFG_CAM_W        = 3'd5,
    CFG_POINT_COUNT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_w;
  } point_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [16:0]        tex_u;
    logic               tex_v;
    logic [12:0]        draw_index_count;
    logic               final_vertex;
  } vertex_t;

endpackage

`default_nettype wire

FILE: hw/rtl/polyline_ribbon_expander_core.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_expander_core: trail points to two-sided ribbon vertices
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) takes one trail point
//    per item. Output channel (out_valid_o / out_stall_i / out_data_o) gives
//    ribbon vertices, plus side then minus side.
//  - Configure over cfg_we_i / cfg_idx_i / cfg_data_i while idle. Writing
//    point_count restarts the trail.
//  - The first point of a trail is stored and gives no vertex. Each later
//    point gives the vertex pair of the point before it; the last point also
//    gives its own pair, the minus vertex flagged final_vertex.
//  - Multiplier, bit-serial normalizer, 32-step root and 32-step divider
//    (tex_u, then each offset component) take turns. The last point's own
//    pair is computed after the pair before it has been loaded for output.
//  - One point is in flight at a time; in_stall_o is high from accept until
//    its last vertex is loaded into the output register.
//  - When out_stall_i is high the output register holds its vertex and the
//    sequencer waits before loading the next one.
//  - Reset: registers take their reset values, output empty, trail restarted.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_ribbon_expander_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire prx_pkg::point_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output prx_pkg::vertex_t      out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_LOADV, ST_NORM, ST_CROSS, ST_SQ, ST_SQRT,
    ST_OFFM, ST_DIV, ST_OFFW, ST_EMIT_P, ST_EMIT_M
  } state_e;

  // configuration
  logic [30:0]        width_q;
  logic               mode_q;
  logic signed [31:0] cam_q [3];
  logic [10:0]        count_q;

  // trail state
  logic [10:0]        idx_q;
  logic signed [31:0] prev_q [3];
  logic signed [31:0] cur_q  [3];
  logic signed [32:0] d_q    [3];
  logic               last_q, side_q;
  logic [16:0]        u_q;

  // shared datapath
  state_e             state_q;
  logic [62:0]        mag_q  [3];
  logic               neg_q  [3];
  logic [1:0]         nsel_q;        // 0: d, 1: look vector, 2: side vector
  logic signed [30:0] dn_q   [3];
  logic signed [30:0] en_q   [3];
  logic signed [62:0] v_q    [3];
  logic signed [63:0] acc_q;
  logic signed [63:0] prod_q;
  logic               ph_q;
  logic [2:0]         j_q;
  logic [63:0]        sx_q, sr_q, sbit_q;
  logic [31:0]        len_q;
  logic [32:0]        rem_q, den_q;
  logic [31:0]        quo_q;
  logic [4:0]         dcnt_q;
  logic               dret_q;        // 0: tex_u, 1: offset component
  logic signed [32:0] off_q  [3];
  logic               out_valid_q;
  prx_pkg::vertex_t   out_q;

  // ---------------------------------------------------------------- comb
  logic [10:0]        n_eff, idx_eff, nm1;
  logic [12:0]        dic;
  logic signed [31:0] pbase [3];
  logic signed [32:0] e_vec [3];
  logic [62:0]        orv;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] acc_n;
  logic [63:0]        sq_t;
  logic [33:0]        div_t;
  logic               div_ge;
  logic               out_free;
  logic               out_load;

  always_comb begin
    n_eff   = (count_q > prx_pkg::MAX_POINTS) ? prx_pkg::MAX_POINTS : count_q;
    idx_eff = (idx_q >= n_eff) ? 11'd0 : idx_q;
    nm1     = n_eff - 11'd1;
    dic     = {nm1, 2'b00} + {1'b0, nm1, 1'b0};
    for (int i = 0; i < 3; i++) begin
      pbase[i] = side_q ? cur_q[i] : prev_q[i];
      e_vec[i] = {cam_q[i][31], cam_q[i]} - {pbase[i][31], pbase[i]};
    end
    orv = mag_q[0] | mag_q[1] | mag_q[2];

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CROSS: begin
        case (j_q)
          3'd0: begin mul_a = 33'(dn_q[1]); mul_b = 33'(en_q[2]); end
          3'd1: begin mul_a = 33'(dn_q[2]); mul_b = 33'(en_q[1]); end
          3'd2: begin mul_a = 33'(dn_q[2]); mul_b = 33'(en_q[0]); end
          3'd3: begin mul_a = 33'(dn_q[0]); mul_b = 33'(en_q[2]); end
          3'd4: begin mul_a = 33'(dn_q[0]); mul_b = 33'(en_q[1]); end
          default: begin mul_a = 33'(dn_q[1]); mul_b = 33'(en_q[0]); end
        endcase
      end
      ST_SQ: begin
        mul_a = {3'b000, mag_q[j_q[1:0]][29:0]};
        mul_b = {3'b000, mag_q[j_q[1:0]][29:0]};
      end
      ST_OFFM: begin
        mul_a = {3'b000, mag_q[j_q[1:0]][29:0]};
        mul_b = {2'b00, width_q};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;

    acc_n  = (state_q == ST_CROSS && j_q[0]) ? acc_q - prod_q : acc_q + prod_q;
    sq_t   = sr_q + sbit_q;
    div_t  = {rem_q, quo_q[31]};
    div_ge = div_t >= {1'b0, den_q};
    out_free = !out_valid_q || !out_stall_i;
    out_load = out_free && (state_q inside {ST_EMIT_P, ST_EMIT_M});
  end

  function automatic logic signed [31:0] sat_add(logic signed [31:0] p,
                                                 logic signed [32:0] o,
                                                 logic minus);
    logic signed [33:0] s;
    s = minus ? 34'(p) - 34'(o) : 34'(p) + 34'(o);
    if (s > 34'sh07FFFFFFF)       return 32'sh7FFFFFFF;
    else if (s < -34'sh080000000) return 32'sh80000000;
    else                          return s[31:0];
  endfunction

  function automatic logic [62:0] abs63(logic signed [62:0] v);
    return v[62] ? 63'(-v) : 63'(v);
  endfunction

  function automatic prx_pkg::vertex_t make_vert(logic signed [31:0] p [3],
                                                 logic signed [32:0] o [3],
                                                 logic minus, logic [16:0] u,
                                                 logic [12:0] dc, logic fin);
    prx_pkg::vertex_t v;
    v.vert_x = sat_add(p[0], o[0], minus);
    v.vert_y = sat_add(p[1], o[1], minus);
    v.vert_z = sat_add(p[2], o[2], minus);
    v.tex_u  = u;
    v.tex_v  = minus;
    v.draw_index_count = dc;
    v.final_vertex = fin;
    return v;
  endfunction

  // ---------------------------------------------------------------- seq
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 31'd65536;
      mode_q      <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        cam_q[i]  <= '0;
        prev_q[i] <= '0;
      end
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && n_eff >= 11'd2) begin
            if (idx_eff == 11'd0) begin
              prev_q[0] <= in_data_i.point_x;
              prev_q[1] <= in_data_i.point_y;
              prev_q[2] <= in_data_i.point_z;
              idx_q     <= 11'd1;
            end else begin
              cur_q[0] <= in_data_i.point_x;
              cur_q[1] <= in_data_i.point_y;
              cur_q[2] <= in_data_i.point_z;
              d_q[0]   <= 33'(prev_q[0]) - 33'(in_data_i.point_x);
              d_q[1]   <= 33'(prev_q[1]) - 33'(in_data_i.point_y);
              d_q[2]   <= 33'(prev_q[2]) - 33'(in_data_i.point_z);
              idx_q    <= idx_eff;
              last_q   <= (idx_eff == nm1);
              side_q   <= 1'b0;
              // tex_u = (k * 2^16 + (n-1)/2) / (n-1)
              rem_q    <= '0;
              quo_q    <= 32'({idx_eff - 11'd1, 16'h0000}) + 32'(nm1 >> 1);
              den_q    <= 33'(nm1);
              dcnt_q   <= '0;
              dret_q   <= 1'b0;
              state_q  <= ST_DIV;
            end
          end
        end

        ST_LOAD: begin
          if (mode_q) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= abs63(63'(d_q[i]));
              neg_q[i] <= d_q[i][32];
            end
            nsel_q  <= 2'd0;
            state_q <= ST_NORM;
          end else begin
            v_q[0]  <= -63'(d_q[1]);
            v_q[1]  <= 63'(d_q[0]);
            v_q[2]  <= '0;
            state_q <= ST_LOADV;
          end
        end

        ST_LOADV: begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= abs63(v_q[i]);
            neg_q[i] <= v_q[i][62];
          end
          nsel_q  <= 2'd2;
          state_q <= ST_NORM;
        end

        // one bit of shift a cycle until the top magnitude sits in [2^29, 2^30)
        ST_NORM: begin
          if (orv != '0 && orv[62:30] != '0) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (orv != '0 && !orv[29]) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            case (nsel_q)
              2'd0: begin
                for (int i = 0; i < 3; i++) begin
                  dn_q[i]  <= neg_q[i] ? -31'(mag_q[i][29:0]) : 31'(mag_q[i][29:0]);
                  mag_q[i] <= abs63(63'(e_vec[i]));
                  neg_q[i] <= e_vec[i][32];
                end
                nsel_q <= 2'd1;
              end
              2'd1: begin
                for (int i = 0; i < 3; i++)
                  en_q[i] <= neg_q[i] ? -31'(mag_q[i][29:0]) : 31'(mag_q[i][29:0]);
                acc_q   <= '0;
                j_q     <= '0;
                ph_q    <= 1'b0;
                state_q <= ST_CROSS;
              end
              default: begin
                if (orv == '0) begin
                  for (int i = 0; i < 3; i++) off_q[i] <= '0;
                  state_q <= ST_EMIT_P;
                end else begin
                  acc_q   <= '0;
                  j_q     <= '0;
                  ph_q    <= 1'b0;
                  state_q <= ST_SQ;
                end
              end
            endcase
          end
        end

        ST_CROSS: begin
          if (!ph_q) begin
            prod_q <= mul_p[63:0];
            ph_q   <= 1'b1;
          end else begin
            ph_q <= 1'b0;
            if (j_q[0]) begin
              v_q[j_q[2:1]] <= acc_n[62:0];
              acc_q         <= '0;
            end else begin
              acc_q <= acc_n;
            end
            j_q <= j_q + 3'd1;
            if (j_q == 3'd5) state_q <= ST_LOADV;
          end
        end

        ST_SQ: begin
          if (!ph_q) begin
            prod_q <= mul_p[63:0];
            ph_q   <= 1'b1;
          end else begin
            ph_q  <= 1'b0;
            acc_q <= acc_n;
            j_q   <= j_q + 3'd1;
            if (j_q == 3'd2) begin
              sx_q    <= acc_n;
              sr_q    <= '0;
              sbit_q  <= 64'd1 << 62;
              state_q <= ST_SQRT;
            end
          end
        end

        // bit-pair integer square root, 32 steps
        ST_SQRT: begin
          if (sx_q >= sq_t) begin
            sx_q <= sx_q - sq_t;
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          if (sbit_q == 64'd1) begin
            len_q   <= (sx_q >= sq_t) ? 32'((sr_q >> 1) + sbit_q) : 32'(sr_q >> 1);
            j_q     <= '0;
            ph_q    <= 1'b0;
            state_q <= ST_OFFM;
          end
        end

        ST_OFFM: begin
          if (!ph_q) begin
            prod_q <= mul_p[63:0];
            ph_q   <= 1'b1;
          end else begin
            // (|c| * width + len) / (2 * len)
            ph_q    <= 1'b0;
            rem_q   <= 33'(prod_q[63:32] + 32'(({32'd0, 32'hFFFFFFFF} & 64'(prod_q))
                        + 64'(len_q) >> 32));
            quo_q   <= prod_q[31:0] + len_q;
            den_q   <= {len_q, 1'b0};
            dcnt_q  <= '0;
            dret_q  <= 1'b1;
            state_q <= ST_DIV;
          end
        end

        // restoring division, one quotient bit a cycle
        ST_DIV: begin
          rem_q  <= div_ge ? 33'(div_t - {1'b0, den_q}) : div_t[32:0];
          quo_q  <= {quo_q[30:0], div_ge};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd31) begin
            if (!dret_q) begin
              u_q     <= {quo_q[15:0], div_ge};
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_OFFW;
            end
          end
        end

        ST_OFFW: begin
          off_q[j_q[1:0]] <= neg_q[j_q[1:0]] ? -33'(quo_q) : 33'(quo_q);
          j_q <= j_q + 3'd1;
          state_q <= (j_q == 3'd2) ? ST_EMIT_P : ST_OFFM;
        end

        ST_EMIT_P: begin
          if (out_free) begin
            out_q <= make_vert(pbase, off_q, 1'b0,
                               side_q ? prx_pkg::TEX_ONE : u_q, 13'd0, 1'b0);
            out_valid_q <= 1'b1;
            state_q     <= ST_EMIT_M;
          end
        end

        ST_EMIT_M: begin
          if (out_free) begin
            out_q <= make_vert(pbase, off_q, 1'b1,
                               side_q ? prx_pkg::TEX_ONE : u_q,
                               side_q ? dic : 13'd0, side_q);
            out_valid_q <= 1'b1;
            if (last_q && !side_q) begin
              side_q  <= 1'b1;
              state_q <= ST_LOAD;
            end else begin
              if (last_q) begin
                idx_q <= '0;
              end else begin
                for (int i = 0; i < 3; i++) prev_q[i] <= cur_q[i];
                idx_q <= idx_q + 11'd1;
              end
              state_q <= ST_IDLE;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase

      if (cfg_we_i) begin
        case (prx_pkg::cfg_idx_e'(cfg_idx_i))
          prx_pkg::CFG_RIBBON_WIDTH: width_q  <= cfg_data_i[30:0];
          prx_pkg::CFG_FACING_MODE:  mode_q   <= cfg_data_i[0];
          prx_pkg::CFG_CAM_X:        cam_q[0] <= cfg_data_i;
          prx_pkg::CFG_CAM_Y:        cam_q[1] <= cfg_data_i;
          prx_pkg::CFG_CAM_Z:        cam_q[2] <= cfg_data_i;
          prx_pkg::CFG_POINT_COUNT: begin
            count_q <= cfg_data_i[10:0];
            idx_q   <= '0;
          end
          default: ;  // cam_w and unused indexes are not stored; no effect
        endcase
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sim/polyline_ribbon_expander_core_test.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_expander_core_test: self-checking bench for the ribbon core
// Sends trail points under several register settings and predicts every
// ribbon vertex in a bit-exact fixed-point model. Both channels idle at
// random, and the output holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_ribbon_expander_core_test;

  typedef longint vec3_t[3];

  localparam int N_POINTS  = 460;
  localparam int SETTLE    = 800;   // > one 4-vertex point at worst latency
  localparam int LONG_HOLD = 3000;

  logic              clk_i, rst_ni;
  logic              in_valid_i, in_stall_o;
  prx_pkg::point_t   in_data_i;
  logic              out_valid_o, out_stall_i;
  prx_pkg::vertex_t  out_data_o;
  logic              cfg_we_i;
  logic [2:0]        cfg_idx_i;
  logic [31:0]       cfg_data_i;

  polyline_ribbon_expander_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Mirror of the block's registers and trail state
  longint unsigned width_q, mode_q, count_q, trail_pos;
  longint          cam_q[3], cam_w_q;
  longint          last_pt[4];

  prx_pkg::point_t  pending_points[$];
  prx_pkg::vertex_t vertex_fifo[$];
  int      errors, vertices_seen, points_used;
  bit      idle_on, hold_req;
  int      in_gap, out_wait, hold_left;
  bit      offering;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("Timeout with %0d vertices still due", vertex_fifo.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // Scale a vector by one common shift so its biggest magnitude is in
  // [2^29, 2^30); magnitudes truncate toward zero. Returns 0 for zero input.
  function automatic bit block_scale(input vec3_t v, output vec3_t o);
    longint unsigned mag[3], m;
    int sr, sl;
    m = 0; sr = 0; sl = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
      if (mag[i] > m) m = mag[i];
      o[i] = 0;
    end
    if (m == 0) return 1'b0;
    while ((m >> sr) >= (64'd1 << prx_pkg::NORM_TOP)) sr++;
    while ((m << sl) < (64'd1 << (prx_pkg::NORM_TOP - 1))) sl++;
    for (int i = 0; i < 3; i++) begin
      m = (mag[i] >> sr) << sl;
      o[i] = v[i] < 0 ? -longint'(m) : longint'(m);
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Half-width offset along the side vector of direction d at point p
  function automatic void side_vector(input vec3_t d, input longint p[4], output vec3_t off);
    vec3_t v, dn, en, e, nv;
    longint unsigned sum, len, mag, q;
    if (mode_q[0]) begin
      for (int i = 0; i < 3; i++) e[i] = cam_q[i] - p[i];
      void'(block_scale(d, dn));
      void'(block_scale(e, en));
      v[0] = dn[1] * en[2] - dn[2] * en[1];
      v[1] = dn[2] * en[0] - dn[0] * en[2];
      v[2] = dn[0] * en[1] - dn[1] * en[0];
    end else begin
      v[0] = -d[1];
      v[1] = d[0];
      v[2] = 0;
    end
    for (int i = 0; i < 3; i++) off[i] = 0;
    if (!block_scale(v, nv)) return;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += longint'(nv[i] * nv[i]);
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      mag = nv[i] < 0 ? longint'(-nv[i]) : nv[i];
      q = (mag * width_q + len) / (2 * len);
      off[i] = nv[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic logic [31:0] clamp32(input longint s);
    if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic void push_pair(input longint p[4], input vec3_t off,
                                    input logic [16:0] u, input bit last,
                                    input longint unsigned n);
    prx_pkg::vertex_t vt;
    for (int s = 0; s < 2; s++) begin
      vt.vert_x = clamp32(s == 0 ? p[0] + off[0] : p[0] - off[0]);
      vt.vert_y = clamp32(s == 0 ? p[1] + off[1] : p[1] - off[1]);
      vt.vert_z = clamp32(s == 0 ? p[2] + off[2] : p[2] - off[2]);
      vt.tex_u = u;
      vt.tex_v = s[0];
      vt.draw_index_count = (last && s == 1) ? 13'((n - 1) * 6) : 13'd0;
      vt.final_vertex = last && s == 1;
      vertex_fifo.push_back(vt);
    end
  endfunction

  // Ribbon vertices caused by one accepted trail point
  function automatic void predict_ribbon(input prx_pkg::point_t pt);
    longint unsigned n, k;
    longint cur[4];
    vec3_t d, off;
    logic [16:0] u;
    n = count_q > longint'(prx_pkg::MAX_POINTS) ? longint'(prx_pkg::MAX_POINTS) : count_q;
    if (n < 2) return;
    if (trail_pos >= n) trail_pos = 0;
    cur[0] = pt.point_x; cur[1] = pt.point_y;
    cur[2] = pt.point_z; cur[3] = pt.point_w;
    if (trail_pos == 0) begin
      last_pt = cur;
      trail_pos = 1;
      return;
    end
    for (int i = 0; i < 3; i++) d[i] = last_pt[i] - cur[i];
    k = trail_pos - 1;
    u = 17'((k * (64'd1 << prx_pkg::FRAC_BITS) + (n - 1) / 2) / (n - 1));
    side_vector(d, last_pt, off);
    push_pair(last_pt, off, u, 1'b0, n);
    if (trail_pos == n - 1) begin
      // last point reuses the previous direction
      side_vector(d, cur, off);
      push_pair(cur, off, prx_pkg::TEX_ONE, 1'b1, n);
      trail_pos = 0;
      return;
    end
    last_pt = cur;
    trail_pos++;
  endfunction

  // ------------------------------------------------------------ input driver
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_ribbon(in_data_i);
      void'(pending_points.pop_front());
      offering = 1'b0;
      in_gap = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !offering) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_points.size() > 0) begin
        in_data_i  <= pending_points[0];
        in_valid_i <= 1'b1;
        offering = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    prx_pkg::vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      vertices_seen++;
      if (vertex_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex %h", $time, out_data_o);
      end else begin
        want = vertex_fifo.pop_front();
        if (out_data_o !== want) begin
          errors++;
          $display("%0t: vertex mismatch exp x=%h y=%h z=%h u=%h v=%b idx=%0d fin=%b",
                   $time, want.vert_x, want.vert_y, want.vert_z, want.tex_u,
                   want.tex_v, want.draw_index_count, want.final_vertex);
          $display("%0t:                 got x=%h y=%h z=%h u=%h v=%b idx=%0d fin=%b",
                   $time, out_data_o.vert_x, out_data_o.vert_y, out_data_o.vert_z,
                   out_data_o.tex_u, out_data_o.tex_v, out_data_o.draw_index_count,
                   out_data_o.final_vertex);
        end
      end
      out_wait = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // Output back-pressure: short random waits, plus one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- sequencer
  task automatic write_reg(input prx_pkg::cfg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      prx_pkg::CFG_RIBBON_WIDTH: width_q = val[30:0];
      prx_pkg::CFG_FACING_MODE:  mode_q  = val[0];
      prx_pkg::CFG_CAM_X:        cam_q[0] = longint'(signed'(val));
      prx_pkg::CFG_CAM_Y:        cam_q[1] = longint'(signed'(val));
      prx_pkg::CFG_CAM_Z:        cam_q[2] = longint'(signed'(val));
      prx_pkg::CFG_CAM_W:        cam_w_q  = longint'(signed'(val));
      prx_pkg::CFG_POINT_COUNT: begin
        count_q = val[10:0];
        trail_pos = 0;
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block is idle: all points taken, all vertices out, last point finished
  task automatic wait_idle();
    while (pending_points.size() != 0 || in_valid_i || vertex_fifo.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_point(input logic [31:0] x, y, z, w);
    prx_pkg::point_t p;
    p.point_x = x; p.point_y = y; p.point_z = z; p.point_w = w;
    pending_points.push_back(p);
  endtask

  initial begin
    int unsigned cnt, npts, r;
    logic [31:0] bx, by, bz;
    bit held;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = prx_pkg::CFG_RIBBON_WIDTH;
    cfg_data_i = '0;
    width_q = 65536; mode_q = 1; cam_q = '{0, 0, 0}; cam_w_q = 65536;
    count_q = 0; trail_pos = 0; last_pt = '{0, 0, 0, 0};
    errors = 0; vertices_seen = 0; points_used = 0;
    idle_on = 1'b1; hold_req = 1'b0; held = 1'b0;
    in_gap = 0; out_wait = 0; hold_left = 0; offering = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, camera at origin: first point sits on the camera,
    // repeated last point gives a zero direction
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'd3);
    add_point(32'd0, 32'd0, 32'd0, 32'd0);
    add_point(32'h0001_0000, 32'd0, 32'd0, 32'hFFFF_FFFF);
    add_point(32'h0001_0000, 32'd0, 32'd0, 32'h8000_0000);
    wait_idle();

    // Flat mode, widest ribbon, points at the range edges: saturating vertices
    write_reg(prx_pkg::CFG_FACING_MODE, 32'd0);
    write_reg(prx_pkg::CFG_RIBBON_WIDTH, 32'h7FFF_FFFF);
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'd3);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    add_point(32'd0, 32'd0, 32'hFFFF_FFFF, 32'h5555_5555);
    wait_idle();

    // Zero width, camera mode, count above the point limit (saturates)
    write_reg(prx_pkg::CFG_RIBBON_WIDTH, 32'd0);
    write_reg(prx_pkg::CFG_FACING_MODE, 32'd1);
    write_reg(prx_pkg::CFG_CAM_X, $urandom);
    write_reg(prx_pkg::CFG_CAM_Y, $urandom);
    write_reg(prx_pkg::CFG_CAM_Z, $urandom);
    write_reg(prx_pkg::CFG_CAM_W, $urandom);
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'h0000_07FF);
    repeat (5) add_point($urandom, $urandom, $urandom, $urandom);
    wait_idle();

    // Short trails are ignored
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'd1);
    repeat (2) add_point($urandom, $urandom, $urandom, $urandom);
    wait_idle();
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'd0);
    add_point($urandom, $urandom, $urandom, $urandom);
    wait_idle();

    // Two-point trail at full width in camera mode
    write_reg(prx_pkg::CFG_RIBBON_WIDTH, 32'h7FFF_FFFF);
    write_reg(prx_pkg::CFG_POINT_COUNT, 32'd2);
    add_point(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 32'd0);
    add_point(32'h0011_0000, 32'h001F_0000, 32'hFFF0_8000, 32'd0);
    wait_idle();
    points_used = 13;

    // Random trails: mostly well-formed, some cut short or overrun
    while (points_used < N_POINTS) begin
      idle_on = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 3);
      write_reg(prx_pkg::CFG_RIBBON_WIDTH,
                r == 0 ? $urandom : $urandom_range(0, 32'h0004_0000));
      write_reg(prx_pkg::CFG_FACING_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        write_reg(prx_pkg::CFG_CAM_X,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000));
        write_reg(prx_pkg::CFG_CAM_Y, $urandom);
        write_reg(prx_pkg::CFG_CAM_Z, $urandom_range(0, 32'h0080_0000));
      end
      r = $urandom_range(0, 9);
      cnt = r == 0 ? $urandom_range(0, 1) : r == 1 ? $urandom_range(13, 40)
                                                   : $urandom_range(2, 8);
      write_reg(prx_pkg::CFG_POINT_COUNT, cnt);
      r = $urandom_range(0, 7);
      npts = cnt < 2 ? 2 : r == 0 ? cnt - 1 : r == 1 ? cnt + 2 : cnt;
      bx = $urandom; by = $urandom; bz = $urandom;
      for (int i = 0; i < npts; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          bx = $urandom; by = $urandom; bz = $urandom;  // wild jump
        end else if (r != 1) begin                      // r == 1 repeats the point
          bx = bx + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          by = by + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          bz = bz + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
        end
        add_point(bx, by, bz, $urandom);
      end
      if (cnt >= 2) points_used += npts;
      // Long output hold while the input keeps offering points
      if (!held && cnt >= 3 && npts >= 3) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      wait_idle();
    end

    $display("Ran %0d trail points through flat and camera-facing ribbons,", points_used);
    $display("checked %0d vertices including saturated and zero-offset cases", vertices_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
